// ----- hdl/wbss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner package
// Shared constants and the configuration register map of the scanner.
// ----------------------------------------------------------------------------
package wbss_pkg;

   // Default bound on the number of signature positions in use.
   localparam int unsigned MAX_PATTERN_BYTES = 16;

   // Number of signature positions that the pattern registers can hold.
   localparam int unsigned REG_POSITIONS = 16;

   // Field widths of the item and result transfers.
   localparam int unsigned DATA_W    = 8;
   localparam int unsigned ADDR_W    = 32;
   localparam int unsigned CSR_W     = 64;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned LEN_W     = 5;
   localparam int unsigned MASK_W    = 16;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PATTERN_LOW    = 2'd0,
      REG_PATTERN_HIGH   = 2'd1,
      REG_WILDCARD_MASK  = 2'd2,
      REG_PATTERN_LENGTH = 2'd3
   } csr_index_type;

endpackage

// ----- hdl/wbss_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner: shift-and match step
// Compares one byte against every signature position, advances the vector of
// partial matches and flags a complete match at the effective length.
// ----------------------------------------------------------------------------
module wbss_match #(
   parameter int unsigned MAX_PATTERN_BYTES = wbss_pkg::MAX_PATTERN_BYTES
) (
   input  logic [wbss_pkg::DATA_W-1:0] data_byte,
   input  logic [wbss_pkg::CSR_W-1:0]  pattern_low,
   input  logic [wbss_pkg::CSR_W-1:0]  pattern_high,
   input  logic [wbss_pkg::MASK_W-1:0] wildcard_mask,
   input  logic [wbss_pkg::LEN_W-1:0]  pattern_length,
   input  logic [((MAX_PATTERN_BYTES < wbss_pkg::REG_POSITIONS) ?
                  MAX_PATTERN_BYTES : wbss_pkg::REG_POSITIONS)-1:0] vec_cur,
   output logic [((MAX_PATTERN_BYTES < wbss_pkg::REG_POSITIONS) ?
                  MAX_PATTERN_BYTES : wbss_pkg::REG_POSITIONS)-1:0] vec_next,
   output logic                        hit,
   output logic [wbss_pkg::LEN_W-1:0]  len_minus_one
);

   localparam int unsigned VEC_W = (MAX_PATTERN_BYTES < wbss_pkg::REG_POSITIONS) ?
                                   MAX_PATTERN_BYTES : wbss_pkg::REG_POSITIONS;

   logic [2*wbss_pkg::CSR_W-1:0]  pattern_all;
   logic [wbss_pkg::LEN_W-1:0]    eff_len;
   logic [VEC_W-1:0]              pos_match;
   logic [VEC_W-1:0]              len_mask;
   logic [VEC_W-1:0]              top_sel;
   logic [VEC_W-1:0]              vec_raw;

   assign pattern_all = {pattern_high, pattern_low};

   // A length of zero counts as one; a length above the bound saturates.
   always_comb begin
      priority if (pattern_length == '0) begin
         eff_len = wbss_pkg::LEN_W'(1);
      end else if (pattern_length > wbss_pkg::LEN_W'(VEC_W)) begin
         eff_len = wbss_pkg::LEN_W'(VEC_W);
      end else begin
         eff_len = pattern_length;
      end
   end

   assign len_minus_one = eff_len - wbss_pkg::LEN_W'(1);

   // Per-position compare, length mask and selection of the final position.
   for (genvar k = 0; k < VEC_W; k++) begin : g_pos
      assign pos_match[k] = wildcard_mask[k] ||
                            (pattern_all[k*wbss_pkg::DATA_W +: wbss_pkg::DATA_W] == data_byte);
      assign len_mask[k]  = (wbss_pkg::LEN_W'(k) < eff_len);
      assign top_sel[k]   = (wbss_pkg::LEN_W'(k) == len_minus_one);
   end

   // Shift in a fresh candidate start and keep the positions that still agree.
   assign vec_raw  = ((vec_cur << 1) | VEC_W'(1)) & pos_match & len_mask;
   assign vec_next = vec_raw;
   assign hit      = |(vec_raw & top_sel);

endmodule

// ----- hdl/wildcard_byte_signature_scanner_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner
// Scans a region one byte per transfer for a signature of up to 16 positions
// with per-position wildcards and reports the first match or a miss.
// ----------------------------------------------------------------------------
//  Channel | Direction | Fields
//  req     | in        | tdata: data_byte [7:0], byte_address [39:8]; tlast: region_end
//  rsp     | out       | tdata: match_address [31:0]; tuser: found
//  csr     | in        | csr_index selects the register, csr_wdata holds the value
//
//  One byte is taken per cycle unless a stalled result holds back a byte that
//  gives one; each byte waits in the input register and its result is written
//  to the result register. The single shift-and step between them sets this rate.
//  Reset is synchronous, resets the scan state and configuration registers and empties both stages.
//  A stalled result holds the result register; the input stage still drains
//  bytes that give no result, and otherwise waits for the result to move.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scanner_core #(
   parameter int unsigned MAX_PATTERN_BYTES = wbss_pkg::MAX_PATTERN_BYTES
) (
   input  logic                           clock,
   input  logic                           reset,
   // Item transfers.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [39:0]                    req_tdata,  // data_byte, byte_address
   input  logic                           req_tlast,
   // Result transfers.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [wbss_pkg::ADDR_W-1:0]    rsp_tdata,  // match_address
   output logic                           rsp_tuser,  // found
   // Configuration writes.
   input  logic                           csr_we,
   input  logic [wbss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wbss_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int unsigned VEC_W = (MAX_PATTERN_BYTES < wbss_pkg::REG_POSITIONS) ?
                                   MAX_PATTERN_BYTES : wbss_pkg::REG_POSITIONS;

   // Configuration registers.
   logic [wbss_pkg::CSR_W-1:0]  pattern_low_ff;
   logic [wbss_pkg::CSR_W-1:0]  pattern_high_ff;
   logic [wbss_pkg::MASK_W-1:0] wildcard_mask_ff;
   logic [wbss_pkg::LEN_W-1:0]  pattern_length_ff;

   // Input stage.
   logic                        in_valid_ff;
   logic [wbss_pkg::DATA_W-1:0] in_data_ff;
   logic [wbss_pkg::ADDR_W-1:0] in_addr_ff;
   logic                        in_last_ff;

   // Scan state.
   logic [VEC_W-1:0]            vec_ff;
   logic [VEC_W-1:0]            vec_in;
   logic                        reported_ff;
   logic                        reported_in;

   // Result stage.
   logic                        rsp_valid_ff;
   logic [wbss_pkg::ADDR_W-1:0] rsp_addr_ff;
   logic                        rsp_found_ff;

   logic [VEC_W-1:0]            vec_step;
   logic                        hit;
   logic [wbss_pkg::LEN_W-1:0]  len_minus_one;
   logic                        has_result;
   logic                        out_free;
   logic                        advance;

   // Configuration write port.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         wildcard_mask_ff  <= '0;
         pattern_length_ff <= wbss_pkg::LEN_W'(1);
      end else if (csr_we) begin
         unique case (wbss_pkg::csr_index_type'(csr_index))
            wbss_pkg::REG_PATTERN_LOW:    pattern_low_ff    <= csr_wdata;
            wbss_pkg::REG_PATTERN_HIGH:   pattern_high_ff   <= csr_wdata;
            wbss_pkg::REG_WILDCARD_MASK:  wildcard_mask_ff  <= csr_wdata[wbss_pkg::MASK_W-1:0];
            wbss_pkg::REG_PATTERN_LENGTH: pattern_length_ff <= csr_wdata[wbss_pkg::LEN_W-1:0];
            default:                      pattern_low_ff    <= pattern_low_ff;
         endcase
      end
   end

   // Match step on the byte in the input register.
   wbss_match #(
      .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
   ) u_match (
      .data_byte     (in_data_ff),
      .pattern_low   (pattern_low_ff),
      .pattern_high  (pattern_high_ff),
      .wildcard_mask (wildcard_mask_ff),
      .pattern_length(pattern_length_ff),
      .vec_cur       (vec_ff),
      .vec_next      (vec_step),
      .hit           (hit),
      .len_minus_one (len_minus_one)
   );

   // Flow control: a byte that gives no result never waits on the output.
   assign has_result = !reported_ff && (hit || in_last_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (out_free || !has_result);
   assign req_tready = !in_valid_ff || advance;

   // Next scan state; the end of a region starts the next one fresh.
   always_comb begin
      vec_in      = vec_ff;
      reported_in = reported_ff;
      priority if (in_last_ff) begin
         vec_in      = '0;
         reported_in = 1'b0;
      end else if (!reported_ff) begin
         vec_in      = vec_step;
         reported_in = hit;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata[wbss_pkg::DATA_W-1:0];
         in_addr_ff <= req_tdata[wbss_pkg::DATA_W +: wbss_pkg::ADDR_W];
         in_last_ff <= req_tlast;
      end
   end

   // Scan state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff      <= '0;
         reported_ff <= 1'b0;
      end else if (advance) begin
         vec_ff      <= vec_in;
         reported_ff <= reported_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         rsp_found_ff <= hit;
         rsp_addr_ff  <= hit ? (in_addr_ff - wbss_pkg::ADDR_W'(len_minus_one)) : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_found_ff;

endmodule

// ----- hdl/wbss_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner checker
// Port-level properties of the scanner, attached to the top level by bind.
// ----------------------------------------------------------------------------
module wbss_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [wbss_pkg::ADDR_W-1:0]    rsp_tdata,
   input logic                           rsp_tuser
);

   // A stalled result transfer holds its valid and its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // A miss always carries a zero address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss result with nonzero address");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // With room on the output side, the scanner always takes a byte.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input stalled with free output");

endmodule

bind wildcard_byte_signature_scanner_core wbss_checker u_wbss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);
